// File: rtl/core/ffra_pkg.sv
// Shared types, codes and constants of the first-fit region allocator.
package ffra_pkg;

  localparam int ADDR_W          = 32;
  localparam int COUNT_W         = 21;
  localparam int DEF_MAX_REGIONS = 32;
  localparam int DEF_PAGE_SHIFT  = 12;

  localparam logic [ADDR_W-1:0] BASE_RESET = 32'h6000_0000;
  localparam logic [ADDR_W-1:0] TOP_RESET  = 32'h8000_0000;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_WINDOW_BASE = 1'b0,
    REG_WINDOW_TOP  = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_GAP = 2'd1,
    ST_FULL   = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef struct packed {
    logic [0:0]         operation;
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] page_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] region_address;
    logic              entry_removed;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_FREE_STEP,
    CMD_SLOT_STEP,
    CMD_GAP_INIT,
    CMD_GAP_SCAN,
    CMD_GAP_STEP,
    CMD_GAP_TOP,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic idx_last;
    logic free_hit;
    logic slot_free;
    logic window_bad;
    logic best_valid;
    logic gap_fit;
    logic top_fit;
    logic out_busy;
  } dp_status_t;

endpackage

// File: rtl/core/ffra_ctrl.sv
// Request sequencer of the first-fit region allocator.
module ffra_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffra_pkg::dp_status_t st,
  output ffra_pkg::cmd_t     cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_FREE     = 8'b0000_0010,
    S_SLOT     = 8'b0000_0100,
    S_GAP_INIT = 8'b0000_1000,
    S_GAP_SCAN = 8'b0001_0000,
    S_GAP_STEP = 8'b0010_0000,
    S_GAP_TOP  = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = ffra_pkg::CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = ffra_pkg::CMD_LOAD;
          state_next = S_FREE;
        end
      end
      S_FREE: begin
        // first cycle after load also routes allocate requests
        if (!st.is_free) begin
          state_next = S_SLOT;
        end else begin
          cmd = ffra_pkg::CMD_FREE_STEP;
          if (st.free_hit || st.idx_last) state_next = S_FINISH;
        end
      end
      S_SLOT: begin
        cmd = ffra_pkg::CMD_SLOT_STEP;
        if (st.slot_free) state_next = S_GAP_INIT;
        else if (st.idx_last) state_next = S_FINISH;
      end
      S_GAP_INIT: begin
        cmd        = ffra_pkg::CMD_GAP_INIT;
        state_next = st.window_bad ? S_FINISH : S_GAP_SCAN;
      end
      S_GAP_SCAN: begin
        cmd = ffra_pkg::CMD_GAP_SCAN;
        if (st.idx_last) state_next = S_GAP_STEP;
      end
      S_GAP_STEP: begin
        cmd = ffra_pkg::CMD_GAP_STEP;
        if (!st.best_valid) state_next = S_GAP_TOP;
        else if (st.gap_fit) state_next = S_FINISH;
        else state_next = S_GAP_SCAN;
      end
      S_GAP_TOP: begin
        cmd        = ffra_pkg::CMD_GAP_TOP;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd        = ffra_pkg::CMD_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// File: rtl/core/ffra_dp.sv
// Region table, window registers, gap search datapath and result register.
module ffra_dp #(
  parameter int MAX_REGIONS = ffra_pkg::DEF_MAX_REGIONS,
  parameter int PAGE_SHIFT  = ffra_pkg::DEF_PAGE_SHIFT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ffra_pkg::in_item_t            in_data,
  input  ffra_pkg::cmd_t                cmd,
  output ffra_pkg::dp_status_t          st,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ffra_pkg::out_item_t           out_data,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [ffra_pkg::ADDR_W-1:0]   cfg_data
);

  localparam int AW = ffra_pkg::ADDR_W;
  localparam int NW = ffra_pkg::COUNT_W;
  localparam int PW = AW - PAGE_SHIFT;
  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = ((PW > NW) ? PW : NW) + 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_REGIONS - 1);
  localparam logic [AW:0]   PAGE_RND = (AW+1)'((64'd1 << PAGE_SHIFT) - 64'd1);

  logic [AW-1:0] window_base, window_top;

  logic [MAX_REGIONS-1:0] valid;
  logic [PW-1:0]          start_mem [MAX_REGIONS];
  logic [NW-1:0]          pages_mem [MAX_REGIONS];

  logic          req_free;
  logic [PW-1:0] req_page;
  logic [NW-1:0] req_count;
  logic [IW-1:0] idx, slot;
  logic [CW-1:0] cursor;
  logic          have_last, best_valid;
  logic [PW+IW-1:0] last_key, best_key;
  logic [NW-1:0]    best_pages;

  logic [1:0]    res_status;
  logic [AW-1:0] res_addr;
  logic          res_removed;

  logic [AW:0]   base_sum;
  logic [CW-1:0] base_pg, top_pg, limit, best_end, best_start_c, cnt_c;
  logic [PW+IW-1:0] cur_key;
  logic          cand, gap_fit, top_fit;

  assign base_sum     = {1'b0, window_base} + PAGE_RND;
  assign base_pg      = CW'(base_sum[AW:PAGE_SHIFT]);
  assign top_pg       = CW'(window_top[AW-1:PAGE_SHIFT]);
  assign cnt_c        = CW'(req_count);
  assign cur_key      = {start_mem[idx], idx};
  assign cand         = valid[idx] && (!have_last || cur_key > last_key)
                        && (!best_valid || cur_key < best_key);
  assign best_start_c = CW'(best_key[PW+IW-1:IW]);
  assign best_end     = best_start_c + CW'(best_pages);
  assign limit        = (best_start_c < top_pg) ? best_start_c : top_pg;
  assign gap_fit      = (limit > cursor) && ((limit - cursor) >= cnt_c);
  assign top_fit      = (top_pg > cursor) && ((top_pg - cursor) >= cnt_c);

  always_comb begin
    st            = '0;
    st.is_free    = req_free;
    st.idx_last   = (idx == IDX_LAST);
    st.free_hit   = valid[idx] && (start_mem[idx] == req_page);
    st.slot_free  = !valid[idx];
    st.window_bad = (req_count == '0) || (base_pg >= top_pg);
    st.best_valid = best_valid;
    st.gap_fit    = gap_fit;
    st.top_fit    = top_fit;
    st.out_busy   = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= ffra_pkg::BASE_RESET;
      window_top  <= ffra_pkg::TOP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ffra_pkg::REG_WINDOW_BASE: window_base <= cfg_data;
        ffra_pkg::REG_WINDOW_TOP:  window_top  <= cfg_data;
        default: ;
      endcase
    end
  end

  // table valid bits and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd == ffra_pkg::CMD_FINISH) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (cmd)
        ffra_pkg::CMD_FREE_STEP: if (st.free_hit) valid[idx] <= 1'b0;
        ffra_pkg::CMD_GAP_STEP:  if (best_valid && gap_fit) valid[slot] <= 1'b1;
        ffra_pkg::CMD_GAP_TOP:   if (top_fit) valid[slot] <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      ffra_pkg::CMD_LOAD: begin
        req_free    <= (in_data.operation == ffra_pkg::OP_FREE);
        req_page    <= in_data.address[AW-1:PAGE_SHIFT];
        req_count   <= in_data.page_count;
        idx         <= '0;
        res_status  <= ffra_pkg::ST_OK;
        res_addr    <= '0;
        res_removed <= 1'b0;
      end
      ffra_pkg::CMD_FREE_STEP: begin
        if (st.free_hit) res_removed <= 1'b1;
        idx <= st.idx_last ? '0 : idx + 1'b1;
      end
      ffra_pkg::CMD_SLOT_STEP: begin
        slot <= idx;
        if (!st.slot_free && st.idx_last) res_status <= ffra_pkg::ST_FULL;
        idx <= st.idx_last ? '0 : idx + 1'b1;
      end
      ffra_pkg::CMD_GAP_INIT: begin
        cursor     <= base_pg;
        idx        <= '0;
        have_last  <= 1'b0;
        best_valid <= 1'b0;
        if (st.window_bad) res_status <= ffra_pkg::ST_NO_GAP;
      end
      ffra_pkg::CMD_GAP_SCAN: begin
        // pick the smallest (start, slot) above the last one taken
        if (cand) begin
          best_valid <= 1'b1;
          best_key   <= cur_key;
          best_pages <= pages_mem[idx];
        end
        idx <= st.idx_last ? '0 : idx + 1'b1;
      end
      ffra_pkg::CMD_GAP_STEP: begin
        if (best_valid) begin
          if (gap_fit) begin
            start_mem[slot] <= cursor[PW-1:0];
            pages_mem[slot] <= req_count;
            res_addr        <= AW'({cursor[PW-1:0], {PAGE_SHIFT{1'b0}}});
          end else begin
            if (best_end > cursor) cursor <= best_end;
            have_last  <= 1'b1;
            last_key   <= best_key;
            best_valid <= 1'b0;
          end
        end
      end
      ffra_pkg::CMD_GAP_TOP: begin
        if (top_fit) begin
          start_mem[slot] <= cursor[PW-1:0];
          pages_mem[slot] <= req_count;
          res_addr        <= AW'({cursor[PW-1:0], {PAGE_SHIFT{1'b0}}});
        end else begin
          res_status <= ffra_pkg::ST_NO_GAP;
        end
      end
      ffra_pkg::CMD_FINISH: begin
        out_data.status         <= res_status;
        out_data.region_address <= res_addr;
        out_data.entry_removed  <= res_removed;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/first_fit_region_allocator.sv
// Top level of the first-fit region allocator.
// Usage: a request on in_data (in_valid/in_stall) either allocates page_count
// pages at the lowest fitting gap of the window or frees the region whose
// first page holds address. Each request gives one result on out_data
// (out_valid/out_stall): status, region_address and entry_removed.
// window_base and window_top are written through cfg_write/cfg_index/cfg_data;
// the user must write them only while no request is in flight, as the block
// itself does not enforce this. A free walks the table one slot a cycle until
// it finds the region or reaches the last slot. An allocate passes a routing
// state, scans for a free slot, then does one full table pass per region
// passed in address order plus a last one. The single table read port is
// stepped by the sequencer.
// One request is handled at a time; in_stall is high until the result has
// been written into the output register, so the next request may be taken
// while that result still waits. A stalled result holds in the register and
// the sequencer waits before writing the next one.
// Reset empties the table and restores the window to its reset values.
module first_fit_region_allocator #(
  parameter int MAX_REGIONS = ffra_pkg::DEF_MAX_REGIONS,
  parameter int PAGE_SHIFT  = ffra_pkg::DEF_PAGE_SHIFT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ffra_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ffra_pkg::out_item_t         out_data,
  input  logic                        cfg_write,
  input  logic [0:0]                  cfg_index,
  input  logic [ffra_pkg::ADDR_W-1:0] cfg_data
);

  ffra_pkg::cmd_t       cmd;
  ffra_pkg::dp_status_t st;

  ffra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ffra_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .PAGE_SHIFT  (PAGE_SHIFT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
